// ----- rtl/core/mft_pkg.sv -----
// ----------------------------------------------------------------------------
// mft_pkg
// shared types and constants of the motor feedback tracker
// ----------------------------------------------------------------------------
package mft_pkg;

    // field widths
    localparam int ID_W    = 11;
    localparam int ANG_W   = 16;
    localparam int SPD_W   = 16;
    localparam int CUR_W   = 16;
    localparam int TMP_W   = 8;
    localparam int CNT_W   = 6;
    localparam int TURN_W  = 19;
    localparam int TOTAL_W = 32;
    localparam int MIDX_W  = 2;
    localparam int LIM_W   = 6;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = ID_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_ID     = 1'b0,
        CFG_CALIB_LIMIT = 1'b1
    } t_cfg_index;

    localparam logic [ID_W-1:0]  BASE_ID_RST     = 11'd513;
    localparam logic [LIM_W-1:0] CALIB_LIMIT_RST = 6'd50;

    localparam int NUM_MOTORS_DEF = 4;

    localparam logic [CNT_W-1:0]         COUNT_MAX = '1;
    localparam logic signed [TURN_W-1:0] TURN_MAX  = 19'sh3FFFF;
    localparam logic signed [TURN_W-1:0] TURN_MIN  = 19'sh40000;
    localparam logic signed [ANG_W:0]    JUMP_POS  = 17'sd4096;
    localparam logic signed [ANG_W:0]    JUMP_NEG  = -17'sd4096;

    // one memory word per motor
    typedef struct packed {
        logic [CNT_W-1:0]         count;
        logic [ANG_W-1:0]         angle;
        logic [ANG_W-1:0]         offset;
        logic signed [SPD_W-1:0]  speed;
        logic signed [TURN_W-1:0] turns;
    } t_motor_state;

    localparam int STATE_W = $bits(t_motor_state);

endpackage

// ----- rtl/core/mft_ram.sv -----
// ----------------------------------------------------------------------------
// mft_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module mft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/motor_feedback_tracker.sv -----
// ----------------------------------------------------------------------------
// motor_feedback_tracker
// per-motor feedback tracking with multi-turn angle unwrap
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  input     in         i_valid / o_ready    frame_id angle_raw speed_raw
//                                            current_raw temp_raw
//  result    out        o_valid / i_ready    motor_index calibrating angle
//                                            speed_avg current temperature
//                                            turns position
//  config    in         i_cfg_we             i_cfg_index i_cfg_data
//
//  one frame per cycle sustained while i_ready holds; o_valid rises after the
//  input transfer, through three registers (ram read, state update, total)
//  per-motor state is one ram word, written back as its frame enters stage 2;
//  a one-deep bypass covers back-to-back frames; out-of-window frames give none
//  synchronous active-low reset; entry valid bits read unwritten words as zero
//  a stage holds only while the one after it is full and stalled
// ----------------------------------------------------------------------------
module motor_feedback_tracker #(
    parameter int NUM_MOTORS = mft_pkg::NUM_MOTORS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration
    input  logic                                  i_cfg_we,
    input  logic [mft_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [mft_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    // input frames
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [mft_pkg::ID_W-1:0]              i_frame_id,
    input  logic [mft_pkg::ANG_W-1:0]             i_angle_raw,
    input  logic signed [mft_pkg::SPD_W-1:0]      i_speed_raw,
    input  logic signed [mft_pkg::CUR_W-1:0]      i_current_raw,
    input  logic [mft_pkg::TMP_W-1:0]             i_temp_raw,
    // results
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [mft_pkg::MIDX_W-1:0]            o_motor_index,
    output logic                                  o_calibrating,
    output logic [mft_pkg::ANG_W-1:0]             o_angle,
    output logic signed [mft_pkg::SPD_W-1:0]      o_speed_avg,
    output logic signed [mft_pkg::CUR_W-1:0]      o_current,
    output logic [mft_pkg::TMP_W-1:0]             o_temperature,
    output logic signed [mft_pkg::TURN_W-1:0]     o_turns,
    output logic signed [mft_pkg::TOTAL_W-1:0]    o_position
);

    import mft_pkg::*;

    localparam int ADDR_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
    localparam logic [ID_W-1:0] NUM_ID = ID_W'(NUM_MOTORS);

    // configuration registers
    logic [ID_W-1:0]  r_base_id;
    logic [LIM_W-1:0] r_calib_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_id     <= BASE_ID_RST;
            r_calib_limit <= CALIB_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_BASE_ID:     r_base_id     <= i_cfg_data;
                CFG_CALIB_LIMIT: r_calib_limit <= i_cfg_data[LIM_W-1:0];
                default:         ;
            endcase
        end
    end

    // stage enables: a stage moves when it is empty or its successor moves
    logic r_s1_valid, r_s2_valid, r_out_valid;
    logic out_en, s2_en, s1_en;

    assign out_en  = !r_out_valid || i_ready;
    assign s2_en   = !r_s2_valid || out_en;
    assign s1_en   = !r_s1_valid || s2_en;
    assign o_ready = s1_en;

    // id window match, no wrap past the top identifier
    logic [ID_W-1:0] id_off;
    logic            id_hit;
    logic            in_xfer;

    assign id_off  = i_frame_id - r_base_id;
    assign id_hit  = (i_frame_id >= r_base_id) && (id_off < NUM_ID);
    assign in_xfer = i_valid && o_ready;

    // stage 1 registers: frame waiting for its ram word
    logic [ADDR_W-1:0]       r_s1_addr;
    logic [MIDX_W-1:0]       r_s1_midx;
    logic [ANG_W-1:0]        r_s1_ang;
    logic signed [SPD_W-1:0] r_s1_spd;
    logic signed [CUR_W-1:0] r_s1_cur;
    logic [TMP_W-1:0]        r_s1_tmp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_en) begin
            r_s1_valid <= in_xfer && id_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_en) begin
            r_s1_addr <= id_off[ADDR_W-1:0];
            r_s1_midx <= id_off[MIDX_W-1:0];
            r_s1_ang  <= i_angle_raw;
            r_s1_spd  <= i_speed_raw;
            r_s1_cur  <= i_current_raw;
            r_s1_tmp  <= i_temp_raw;
        end
    end

    // state memory; a held stage re-reads its own entry
    logic [ADDR_W-1:0]   ram_raddr;
    logic [STATE_W-1:0]  ram_rdata;
    logic                wr_en;
    t_motor_state        n_state;
    logic [NUM_MOTORS-1:0] r_ent_vld;
    logic                r_rd_vld;

    assign ram_raddr = s1_en ? id_off[ADDR_W-1:0] : r_s1_addr;
    assign wr_en     = r_s1_valid && s2_en;

    mft_ram #(
        .WIDTH (STATE_W),
        .DEPTH (NUM_MOTORS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_s1_addr),
        .i_wdata (n_state),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // entry valid bits stand in for the all-zero reset contents
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (wr_en) begin
                r_ent_vld[r_s1_addr] <= 1'b1;
            end
            r_rd_vld <= r_ent_vld[ram_raddr];
        end
    end

    // bypass of the write that landed on the same edge as the read
    logic              r_fwd_valid;
    logic [ADDR_W-1:0] r_fwd_addr;
    t_motor_state      r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else begin
            r_fwd_valid <= wr_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_fwd_addr <= r_s1_addr;
            r_fwd_data <= n_state;
        end
    end

    t_motor_state cur_state;

    always_comb begin
        if (r_fwd_valid && (r_fwd_addr == r_s1_addr)) begin
            cur_state = r_fwd_data;
        end else if (r_rd_vld) begin
            cur_state = t_motor_state'(ram_rdata);
        end else begin
            cur_state = '0;
        end
    end

    // shared averaging toggle, flips on each measuring frame of any motor
    logic r_avg_toggle;
    logic n_avg_toggle;

    // state update
    logic                     calib;
    logic signed [SPD_W:0]    spd_sum;
    logic signed [SPD_W:0]    spd_adj;
    logic signed [ANG_W:0]    ang_diff;
    logic signed [CUR_W-1:0]  n_cur;
    logic [TMP_W-1:0]         n_tmp;

    always_comb begin
        calib        = cur_state.count <= r_calib_limit;
        n_state      = cur_state;
        n_avg_toggle = r_avg_toggle;
        n_cur        = r_s1_cur;
        n_tmp        = r_s1_tmp;
        spd_sum      = '0;
        spd_adj      = '0;
        ang_diff     = $signed({1'b0, r_s1_ang}) - $signed({1'b0, cur_state.angle});

        if (cur_state.count != COUNT_MAX) begin
            n_state.count = cur_state.count + CNT_W'(1);
        end
        n_state.angle = r_s1_ang;

        if (calib) begin
            // offset latch; current and temperature read as zero
            n_state.offset = r_s1_ang;
            n_cur          = '0;
            n_tmp          = '0;
        end else begin
            // on alternate measuring frames, average with the previous speed, truncating toward zero
            if (r_avg_toggle) begin
                spd_sum       = $signed({r_s1_spd[SPD_W-1], r_s1_spd})
                              + $signed({cur_state.speed[SPD_W-1], cur_state.speed});
                spd_adj       = spd_sum + $signed({{SPD_W{1'b0}}, spd_sum[SPD_W]});
                n_state.speed = spd_adj[SPD_W:1];
            end else begin
                n_state.speed = r_s1_spd;
            end
            n_avg_toggle = !r_avg_toggle;

            // wrap detection, saturating turn count
            if (ang_diff > JUMP_POS) begin
                if (cur_state.turns != TURN_MIN) begin
                    n_state.turns = cur_state.turns - TURN_W'(1);
                end
            end else if (ang_diff < JUMP_NEG) begin
                if (cur_state.turns != TURN_MAX) begin
                    n_state.turns = cur_state.turns + TURN_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg_toggle <= 1'b0;
        end else if (wr_en) begin
            r_avg_toggle <= n_avg_toggle;
        end
    end

    // stage 2 registers: updated state, total not yet formed
    logic [MIDX_W-1:0]        r_s2_midx;
    logic                     r_s2_calib;
    logic [ANG_W-1:0]         r_s2_ang;
    logic [ANG_W-1:0]         r_s2_off;
    logic signed [SPD_W-1:0]  r_s2_spd;
    logic signed [CUR_W-1:0]  r_s2_cur;
    logic [TMP_W-1:0]         r_s2_tmp;
    logic signed [TURN_W-1:0] r_s2_turns;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_en) begin
            r_s2_midx  <= r_s1_midx;
            r_s2_calib <= calib;
            r_s2_ang   <= n_state.angle;
            r_s2_off   <= n_state.offset;
            r_s2_spd   <= n_state.speed;
            r_s2_cur   <= n_cur;
            r_s2_tmp   <= n_tmp;
            r_s2_turns <= n_state.turns;
        end
    end

    // total = turns*8192 + angle - offset, saturated to 32 bits
    logic signed [TOTAL_W+1:0] total_sum;
    logic signed [TOTAL_W-1:0] total_sat;

    always_comb begin
        total_sum = $signed({{2{r_s2_turns[TURN_W-1]}}, r_s2_turns, 13'b0})
                  + $signed({{(TOTAL_W+2-ANG_W){1'b0}}, r_s2_ang})
                  - $signed({{(TOTAL_W+2-ANG_W){1'b0}}, r_s2_off});
        if (total_sum[TOTAL_W+1:TOTAL_W-1] inside {3'b000, 3'b111}) begin
            total_sat = total_sum[TOTAL_W-1:0];
        end else if (total_sum[TOTAL_W+1]) begin
            total_sat = {1'b1, {(TOTAL_W-1){1'b0}}};
        end else begin
            total_sat = {1'b0, {(TOTAL_W-1){1'b1}}};
        end
    end

    // output register
    logic [MIDX_W-1:0]         r_out_midx;
    logic                      r_out_calib;
    logic [ANG_W-1:0]          r_out_ang;
    logic signed [SPD_W-1:0]   r_out_spd;
    logic signed [CUR_W-1:0]   r_out_cur;
    logic [TMP_W-1:0]          r_out_tmp;
    logic signed [TURN_W-1:0]  r_out_turns;
    logic signed [TOTAL_W-1:0] r_out_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_en) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_en) begin
            r_out_midx  <= r_s2_midx;
            r_out_calib <= r_s2_calib;
            r_out_ang   <= r_s2_ang;
            r_out_spd   <= r_s2_spd;
            r_out_cur   <= r_s2_cur;
            r_out_tmp   <= r_s2_tmp;
            r_out_turns <= r_s2_turns;
            r_out_total <= total_sat;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_motor_index = r_out_midx;
    assign o_calibrating = r_out_calib;
    assign o_angle       = r_out_ang;
    assign o_speed_avg   = r_out_spd;
    assign o_current     = r_out_cur;
    assign o_temperature = r_out_tmp;
    assign o_turns       = r_out_turns;
    assign o_position    = r_out_total;

endmodule

// ----- rtl/core/mft_checker.sv -----
// ----------------------------------------------------------------------------
// mft_checker
// port-level checks of the motor feedback tracker
// ----------------------------------------------------------------------------
module mft_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_valid,
    input logic                               i_ready,
    input logic                               o_calibrating,
    input logic signed [mft_pkg::CUR_W-1:0]   o_current,
    input logic [mft_pkg::TMP_W-1:0]          o_temperature,
    input logic signed [mft_pkg::TURN_W-1:0]  o_turns,
    input logic signed [mft_pkg::TOTAL_W-1:0] o_position
);

    import mft_pkg::*;

    // no result right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // a stalled result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_position) && $stable(o_turns))
        else $error("stalled result changed");

    // offset latch frames carry no current or temperature
    a_calib_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_calibrating |-> (o_current == '0) && (o_temperature == '0))
        else $error("calibrating result with nonzero current or temperature");

    // angle equals offset while calibrating, so the total is whole turns
    a_calib_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_calibrating |->
            (o_position[12:0] == '0) && (o_position[TOTAL_W-1:13] == o_turns))
        else $error("calibrating total is not whole turns");

endmodule

bind motor_feedback_tracker mft_checker u_mft_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_calibrating (o_calibrating),
    .o_current     (o_current),
    .o_temperature (o_temperature),
    .o_turns       (o_turns),
    .o_position    (o_position)
);
